### rtl/blzu_pkg.sv
`default_nettype none

package blzu_pkg;

  localparam int unsigned WINDOW_BYTES_DEF = 4096;
  localparam int unsigned BYTE_W           = 8;

  typedef struct packed {
    logic        mode;
    logic [31:0] word;
    logic        last_word;
  } in_req_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic        out_valid;
    logic [31:0] position;
    logic        need_word;
    logic [2:0]  status;
  } out_res_t;

  typedef struct packed {
    logic load_req;
    logic word_op;
    logic bit_op;
    logic read_op;
    logic copy_op;
    logic out_load;
  } ctl_cmd_t;

  typedef struct packed {
    logic mode;
    logic halted;
    logic blocked;
    logic phase_copy;
    logic bit_last;
  } ctl_sts_t;

endpackage

`default_nettype wire

### rtl/blzu_ram.sv
`default_nettype none

module blzu_ram #(
  parameter int unsigned WIDTH = blzu_pkg::BYTE_W,
  parameter int unsigned DEPTH = blzu_pkg::WINDOW_BYTES_DEF,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

### rtl/blzu_ctrl.sv
`default_nettype none

module blzu_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  input  blzu_pkg::ctl_sts_t  sts_i,
  output blzu_pkg::ctl_cmd_t  cmd_o
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DISP = 3'd1;
  localparam logic [2:0] S_BIT  = 3'd2;
  localparam logic [2:0] S_RD   = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;

  logic [2:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       in_acc;

  assign in_stall_o  = (state_q != S_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    out_valid_d = out_valid_q && out_stall_i;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          cmd_o.load_req = 1'b1;
          state_d        = S_DISP;
        end
      end
      S_DISP: begin
        if (!sts_i.mode) begin
          cmd_o.word_op = 1'b1;
          state_d       = S_FIN;
        end else if (sts_i.halted || sts_i.blocked) begin
          state_d = S_FIN;
        end else begin
          state_d = S_BIT;
        end
      end
      S_BIT: begin
        if (sts_i.phase_copy) begin
          cmd_o.read_op = 1'b1;
          state_d       = S_RD;
        end else begin
          cmd_o.bit_op = 1'b1;
          if (sts_i.bit_last) begin
            state_d = S_FIN;
          end
        end
      end
      S_RD: begin
        cmd_o.copy_op = 1'b1;
        state_d       = S_FIN;
      end
      S_FIN: begin
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

`ifndef SYNTHESIS
  a_copy_after_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.read_op |=> (state_q == S_RD && cmd_o.copy_op))
    else $error("history copy does not follow its read");

  a_result_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && state_q != S_FIN) |=> !out_valid_o)
    else $error("delivered result shown again");

  a_load_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |=> (out_valid_o && state_q == S_IDLE))
    else $error("result load did not present a result");

  a_hold_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FIN && out_valid_o && out_stall_i) |=> (state_q == S_FIN))
    else $error("finished request left while output is full");
`endif

endmodule

`default_nettype wire

### rtl/blzu_dpath.sv
`default_nettype none

module blzu_dpath #(
  parameter int unsigned WINDOW_BYTES = blzu_pkg::WINDOW_BYTES_DEF,
  localparam int unsigned AW          = $clog2(WINDOW_BYTES)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  blzu_pkg::in_req_t   in_req_i,
  input  blzu_pkg::ctl_cmd_t  cmd_i,
  output blzu_pkg::ctl_sts_t  sts_o,
  output blzu_pkg::out_res_t  out_res_o,
  output logic                ram_we_o,
  output logic [AW-1:0]       ram_waddr_o,
  output logic [7:0]          ram_wdata_o,
  output logic                ram_re_o,
  output logic [AW-1:0]       ram_raddr_o,
  input  logic [7:0]          ram_rdata_i
);

  localparam int unsigned FW = $clog2(WINDOW_BYTES + 1);

  localparam logic [31:0] MARK_BIT = 32'h8000_0000;

  localparam logic [3:0] PH_CMD0   = 4'd0;
  localparam logic [3:0] PH_CMD1   = 4'd1;
  localparam logic [3:0] PH_SEL    = 4'd2;
  localparam logic [3:0] PH_LITN_S = 4'd3;
  localparam logic [3:0] PH_LITN_L = 4'd4;
  localparam logic [3:0] PH_CPYN   = 4'd5;
  localparam logic [3:0] PH_OFF    = 4'd6;
  localparam logic [3:0] PH_LIT    = 4'd7;
  localparam logic [3:0] PH_COPY   = 4'd8;

  localparam logic [2:0] ST_RUN   = 3'd0;
  localparam logic [2:0] ST_OK    = 3'd1;
  localparam logic [2:0] ST_BAD   = 3'd2;
  localparam logic [2:0] ST_EXH   = 3'd3;
  localparam logic [2:0] ST_UNEXP = 3'd4;

  localparam logic [1:0] HDR_DONE = 2'd3;

  blzu_pkg::in_req_t  req_q, req_d;
  blzu_pkg::out_res_t out_q, out_d;

  logic [31:0]   chunk_q, chunk_d;
  logic [31:0]   csum_q, csum_d;
  logic [31:0]   left_q, left_d;
  logic [31:0]   oidx_q, oidx_d;
  logic [1:0]    hdr_q, hdr_d;
  logic [3:0]    phase_q, phase_d;
  logic [11:0]   acc_q, acc_d;
  logic [3:0]    fbl_q, fbl_d;
  logic [8:0]    run_q, run_d;
  logic [11:0]   off_q, off_d;
  logic          ended_q, ended_d;
  logic          fresh_q, fresh_d;
  logic          wait_q, wait_d;
  logic [2:0]    fin_q, fin_d;
  logic [FW-1:0] fill_q, fill_d;
  logic [7:0]    res_byte_q, res_byte_d;
  logic          res_vld_q, res_vld_d;
  logic [31:0]   res_pos_q, res_pos_d;
  logic          res_bad_q, res_bad_d;

  logic          bit_ok;
  logic          bit_val;
  logic [11:0]   acc_n;
  logic [3:0]    fbl_n;
  logic [8:0]    run_dec;
  logic [8:0]    run_new;
  logic          emit_en;
  logic [7:0]    emit_val;
  logic          end_cmd;
  logic          ended_n;
  logic          copy_hit;
  logic [7:0]    copy_val;
  logic          blocked;

  function automatic logic [31:0] f_consume(input logic [31:0] left, input logic [8:0] n);
    f_consume = ({23'd0, n} > left) ? 32'd0 : left - {23'd0, n};
  endfunction

  assign bit_val  = chunk_q[0];
  assign acc_n    = {acc_q[10:0], bit_val};
  assign fbl_n    = fbl_q - 4'd1;
  assign run_dec  = run_q - 9'd1;
  assign blocked  = (hdr_q != HDR_DONE) || wait_q;
  assign copy_hit = (off_q != 12'd0) && (FW'(off_q) <= fill_q);
  assign copy_val = copy_hit ? ram_rdata_i : 8'd0;

  assign sts_o.mode       = req_q.mode;
  assign sts_o.halted     = (fin_q != ST_RUN);
  assign sts_o.blocked    = blocked;
  assign sts_o.phase_copy = (phase_q == PH_COPY);
  assign sts_o.bit_last   = (!fresh_q && (chunk_q[31:1] == 31'd0))
                          || (phase_q == PH_LIT && fbl_q == 4'd1);

  assign ram_we_o    = emit_en;
  assign ram_waddr_o = oidx_q[AW-1:0];
  assign ram_wdata_o = emit_val;
  assign ram_re_o    = cmd_i.read_op;
  assign ram_raddr_o = oidx_q[AW-1:0] + AW'(off_q);

  assign out_res_o = out_q;

  always_comb begin
    req_d      = req_q;
    out_d      = out_q;
    chunk_d    = chunk_q;
    csum_d     = csum_q;
    left_d     = left_q;
    oidx_d     = oidx_q;
    hdr_d      = hdr_q;
    phase_d    = phase_q;
    acc_d      = acc_q;
    fbl_d      = fbl_q;
    run_d      = run_q;
    off_d      = off_q;
    ended_d    = ended_q;
    fresh_d    = fresh_q;
    wait_d     = wait_q;
    fin_d      = fin_q;
    fill_d     = fill_q;
    res_byte_d = res_byte_q;
    res_vld_d  = res_vld_q;
    res_pos_d  = res_pos_q;
    res_bad_d  = res_bad_q;
    bit_ok     = 1'b0;
    run_new    = run_q;
    emit_en    = 1'b0;
    emit_val   = 8'd0;
    end_cmd    = 1'b0;
    ended_n    = ended_q;

    if (cmd_i.load_req) begin
      req_d      = in_req_i;
      res_byte_d = 8'd0;
      res_vld_d  = 1'b0;
      res_pos_d  = 32'd0;
      res_bad_d  = 1'b0;
    end

    if (cmd_i.word_op) begin
      if (fin_q != ST_RUN || !blocked) begin
        res_bad_d = 1'b1;
      end else begin
        case (hdr_q)
          2'd0: begin
            left_d = req_q.word;
            oidx_d = req_q.word - 32'd1;
            hdr_d  = 2'd1;
          end
          2'd1: begin
            csum_d = req_q.word;
            hdr_d  = 2'd2;
          end
          2'd2: begin
            chunk_d = req_q.word;
            csum_d  = csum_q ^ req_q.word;
            fresh_d = 1'b0;
            hdr_d   = HDR_DONE;
          end
          default: begin
            chunk_d = req_q.word;
            csum_d  = csum_q ^ req_q.word;
            fresh_d = 1'b1;
            wait_d  = 1'b0;
          end
        endcase
        ended_n = ended_q | req_q.last_word;
        ended_d = ended_n;
        if (hdr_d != HDR_DONE && ended_n) begin
          fin_d = ST_EXH;
        end
      end
    end

    if (cmd_i.bit_op) begin
      bit_ok = 1'b1;
      if (fresh_q) begin
        chunk_d = MARK_BIT | (chunk_q >> 1);
        fresh_d = 1'b0;
      end else if (chunk_q[31:1] == 31'd0) begin
        bit_ok  = 1'b0;
        chunk_d = 32'd0;
        wait_d  = 1'b1;
        if (ended_q) begin
          wait_d = 1'b0;
          fin_d  = ST_EXH;
        end
      end else begin
        chunk_d = chunk_q >> 1;
      end

      if (bit_ok) begin
        case (phase_q)
          PH_CMD0: begin
            if (bit_val) begin
              acc_d   = 12'd0;
              fbl_d   = 4'd2;
              phase_d = PH_SEL;
            end else begin
              phase_d = PH_CMD1;
            end
          end
          PH_CMD1: begin
            acc_d = 12'd0;
            if (bit_val) begin
              run_d   = 9'd2;
              fbl_d   = 4'd8;
              phase_d = PH_OFF;
            end else begin
              fbl_d   = 4'd3;
              phase_d = PH_LITN_S;
            end
          end
          PH_SEL, PH_LITN_S, PH_LITN_L, PH_CPYN, PH_OFF, PH_LIT: begin
            if (fbl_q == 4'd0 || fbl_q > 4'd12) begin
              phase_d = PH_CMD0;
            end else begin
              acc_d = acc_n;
              fbl_d = fbl_n;
              if (fbl_n == 4'd0) begin
                case (phase_q)
                  PH_SEL: begin
                    acc_d = 12'd0;
                    if (acc_n == 12'd3) begin
                      fbl_d   = 4'd8;
                      phase_d = PH_LITN_L;
                    end else if (acc_n < 12'd2) begin
                      run_d   = {8'd0, acc_n[0]} + 9'd3;
                      fbl_d   = {3'd0, acc_n[0]} + 4'd9;
                      phase_d = PH_OFF;
                    end else begin
                      fbl_d   = 4'd8;
                      phase_d = PH_CPYN;
                    end
                  end
                  PH_CPYN: begin
                    run_d   = {1'b0, acc_n[7:0]} + 9'd1;
                    acc_d   = 12'd0;
                    fbl_d   = 4'd12;
                    phase_d = PH_OFF;
                  end
                  PH_OFF: begin
                    off_d   = acc_n;
                    left_d  = f_consume(left_q, run_q);
                    phase_d = PH_COPY;
                  end
                  PH_LITN_S: begin
                    run_new = {1'b0, acc_n[7:0]} + 9'd1;
                    run_d   = run_new;
                    left_d  = f_consume(left_q, run_new);
                    acc_d   = 12'd0;
                    fbl_d   = 4'd8;
                    phase_d = PH_LIT;
                  end
                  PH_LITN_L: begin
                    run_new = {1'b0, acc_n[7:0]} + 9'd9;
                    run_d   = run_new;
                    left_d  = f_consume(left_q, run_new);
                    acc_d   = 12'd0;
                    fbl_d   = 4'd8;
                    phase_d = PH_LIT;
                  end
                  default: begin
                    emit_en  = 1'b1;
                    emit_val = acc_n[7:0];
                    run_d    = run_dec;
                    if (run_dec == 9'd0) begin
                      end_cmd = 1'b1;
                    end else begin
                      acc_d   = 12'd0;
                      fbl_d   = 4'd8;
                      phase_d = PH_LIT;
                    end
                  end
                endcase
              end
            end
          end
          default: begin
            phase_d = PH_CMD0;
          end
        endcase
      end
    end

    if (cmd_i.copy_op) begin
      emit_en  = 1'b1;
      emit_val = copy_val;
      run_d    = run_dec;
      if (run_dec == 9'd0) begin
        end_cmd = 1'b1;
      end
    end

    if (emit_en) begin
      res_byte_d = emit_val;
      res_vld_d  = 1'b1;
      res_pos_d  = oidx_q;
      oidx_d     = oidx_q - 32'd1;
      if (fill_q != FW'(WINDOW_BYTES)) begin
        fill_d = fill_q + FW'(1);
      end
    end

    if (end_cmd) begin
      phase_d = PH_CMD0;
      if (left_q == 32'd0) begin
        fin_d = (csum_q == 32'd0) ? ST_OK : ST_BAD;
      end
    end

    if (cmd_i.out_load) begin
      out_d.out_byte  = res_byte_q;
      out_d.out_valid = res_vld_q;
      out_d.position  = res_pos_q;
      out_d.need_word = (fin_q == ST_RUN) && blocked;
      out_d.status    = res_bad_q ? ST_UNEXP : fin_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chunk_q <= 32'd0;
      csum_q  <= 32'd0;
      left_q  <= 32'd0;
      oidx_q  <= 32'd0;
      hdr_q   <= 2'd0;
      phase_q <= PH_CMD0;
      acc_q   <= 12'd0;
      fbl_q   <= 4'd0;
      run_q   <= 9'd0;
      off_q   <= 12'd0;
      ended_q <= 1'b0;
      fresh_q <= 1'b0;
      wait_q  <= 1'b0;
      fin_q   <= ST_RUN;
      fill_q  <= '0;
    end else begin
      chunk_q <= chunk_d;
      csum_q  <= csum_d;
      left_q  <= left_d;
      oidx_q  <= oidx_d;
      hdr_q   <= hdr_d;
      phase_q <= phase_d;
      acc_q   <= acc_d;
      fbl_q   <= fbl_d;
      run_q   <= run_d;
      off_q   <= off_d;
      ended_q <= ended_d;
      fresh_q <= fresh_d;
      wait_q  <= wait_d;
      fin_q   <= fin_d;
      fill_q  <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q      <= req_d;
    out_q      <= out_d;
    res_byte_q <= res_byte_d;
    res_vld_q  <= res_vld_d;
    res_pos_q  <= res_pos_d;
    res_bad_q  <= res_bad_d;
  end

endmodule

`default_nettype wire

### rtl/backward_lz_bitstream_unpacker.sv
// Timing: a word request or a step with no work goes straight to its result; a step
//   parses command bits, and a copied history byte adds a RAM read and then its write.
// Throughput: requests are taken one at a time, in_stall_o staying high until the
//   result is loaded; command bits go one per cycle within a step.
// Reset: rst_ni clears all stream state at once; history needs no clearing pass,
//   a fill count makes entries not yet written since reset read as zero.
`default_nettype none

module backward_lz_bitstream_unpacker #(
  parameter int unsigned WINDOW_BYTES = blzu_pkg::WINDOW_BYTES_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  blzu_pkg::in_req_t  in_req_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output blzu_pkg::out_res_t out_res_o
);

  localparam int unsigned AW = $clog2(WINDOW_BYTES);

  blzu_pkg::ctl_cmd_t cmd;
  blzu_pkg::ctl_sts_t sts;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [7:0]    ram_wdata;
  logic          ram_re;
  logic [AW-1:0] ram_raddr;
  logic [7:0]    ram_rdata;

  blzu_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  blzu_dpath #(
    .WINDOW_BYTES (WINDOW_BYTES)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_req_i    (in_req_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_res_o   (out_res_o),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_re_o    (ram_re),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata)
  );

  blzu_ram #(
    .WIDTH (blzu_pkg::BYTE_W),
    .DEPTH (WINDOW_BYTES)
  ) u_hist (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

endmodule

`default_nettype wire
